// ===== hw/rtl/awtm_pkg.sv =====
package awtm_pkg;

    localparam int MAX_WINDOWS_DEF = 32;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int COUNT_W    = 6;

    localparam logic [COUNT_W-1:0] WINDOW_COUNT_RST = 6'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COUNT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_BASE_MODE = 8'd1;

    localparam logic OP_ENABLE  = 1'b0;
    localparam logic OP_DISABLE = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FREE   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [31:0] EN_BIT     = 32'h8000_0000;
    localparam int          TARGET_LSB = 20;
    localparam logic [63:0] SHORT_MASK = 64'h0000_0FFF_FFFF_F000;

    typedef struct packed {
        logic [63:0] base;
        logic [31:0] status;
    } t_win_entry;

    typedef struct packed {
        logic       rd_en;
        logic       wr_en;
        t_win_entry wr_data;
    } t_mem_req;

    // 1-based position of the highest set bit, 0 when no bit is set
    function automatic logic [5:0] high_bit_pos(input logic [31:0] x);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                p = 6'(i + 1);
            end
        end
        return p;
    endfunction

endpackage

// ===== hw/rtl/access_window_table_manager.sv =====
// Channel   Direction  Handshake                    Payload
// request   in         start & !busy                i_opcode i_target i_base i_size
// result    out        o_done (one cycle)           o_status o_slot_written o_slot
// config    in         i_cfg_valid & o_cfg_ready    i_cfg_index i_cfg_data
//
// One request at a time: after accept the request steps through S_SUM, S_CODE, S_SCAN
// (n = windows in use, up to MAX_WINDOWS), S_LAST and S_RESP; the result strobe follows,
// busy drops with it, and only then is a new request taken. With no window in use S_SCAN and S_LAST are skipped.
// The scan reads the window memory one window a cycle.
// Reset (synchronous, active low) clears the per-window valid bits at once: no sweep.
// The result receiver cannot stall; config is always ready.
module access_window_table_manager #(
    parameter int MAX_WINDOWS = awtm_pkg::MAX_WINDOWS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_opcode,
    input  logic [7:0]                       i_target,
    input  logic [63:0]                      i_base,
    input  logic [31:0]                      i_size,
    output logic                             o_done,
    output logic [1:0]                       o_status,
    output logic                             o_slot_written,
    output logic [4:0]                       o_slot,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [awtm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [awtm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import awtm_pkg::*;

    localparam int IW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

    logic [COUNT_W-1:0] r_window_count;
    logic               r_wide_base_mode;
    t_mem_req           mem_req;
    logic [IW-1:0]      mem_addr;
    t_win_entry         rd_entry;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_count   <= WINDOW_COUNT_RST;
            r_wide_base_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WINDOW_COUNT:   r_window_count   <= i_cfg_data[COUNT_W-1:0];
                REG_WIDE_BASE_MODE: r_wide_base_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    awtm_ctrl #(
        .MAX_WINDOWS (MAX_WINDOWS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .o_busy           (busy),
        .i_opcode         (i_opcode),
        .i_target         (i_target),
        .i_base           (i_base),
        .i_size           (i_size),
        .i_window_count   (r_window_count),
        .i_wide_base_mode (r_wide_base_mode),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_slot_written   (o_slot_written),
        .o_slot           (o_slot),
        .o_mem_req        (mem_req),
        .o_addr           (mem_addr),
        .i_rd_entry       (rd_entry)
    );

    awtm_table #(
        .MAX_WINDOWS (MAX_WINDOWS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mem_req  (mem_req),
        .i_addr     (mem_addr),
        .o_rd_entry (rd_entry)
    );

endmodule

// ===== hw/rtl/awtm_table.sv =====
module awtm_table #(
    parameter int MAX_WINDOWS = awtm_pkg::MAX_WINDOWS_DEF,
    localparam int IW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  awtm_pkg::t_mem_req    i_mem_req,
    input  logic [IW-1:0]         i_addr,
    output awtm_pkg::t_win_entry  o_rd_entry
);
    import awtm_pkg::*;

    t_win_entry             r_mem [MAX_WINDOWS];
    logic [MAX_WINDOWS-1:0] r_valid;
    t_win_entry             r_rd;
    logic                   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_mem_req.wr_en) begin
            r_mem[i_addr] <= i_mem_req.wr_data;
        end
        if (i_mem_req.rd_en) begin
            r_rd <= r_mem[i_addr];
        end
    end

    // an entry never written since reset reads as a cleared window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_mem_req.wr_en) begin
                r_valid[i_addr] <= 1'b1;
            end
            if (i_mem_req.rd_en) begin
                r_rd_valid <= r_valid[i_addr];
            end
        end
    end

    assign o_rd_entry = r_rd_valid ? r_rd : '0;

endmodule

// ===== hw/rtl/awtm_ctrl.sv =====
module awtm_ctrl #(
    parameter int MAX_WINDOWS = awtm_pkg::MAX_WINDOWS_DEF,
    localparam int IW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_opcode,
    input  logic [7:0]                    i_target,
    input  logic [63:0]                   i_base,
    input  logic [31:0]                   i_size,
    input  logic [awtm_pkg::COUNT_W-1:0]  i_window_count,
    input  logic                          i_wide_base_mode,
    output logic                          o_done,
    output logic [1:0]                    o_status,
    output logic                          o_slot_written,
    output logic [4:0]                    o_slot,
    output awtm_pkg::t_mem_req            o_mem_req,
    output logic [IW-1:0]                 o_addr,
    input  awtm_pkg::t_win_entry          i_rd_entry
);
    import awtm_pkg::*;

    localparam int CW = $clog2(MAX_WINDOWS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_CODE = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_LAST = 3'd4;
    localparam logic [2:0] S_RESP = 3'd5;

    logic [2:0]    r_state, n_state;
    logic          r_opcode;
    logic [7:0]    r_target;
    logic [63:0]   r_base;
    logic [31:0]   r_size;
    logic [CW-1:0] r_n, n_n;
    logic [31:0]   r_sum;
    logic [31:0]   r_sw, n_sw;
    logic [IW-1:0] r_addr;
    logic          r_chk;
    logic [IW-1:0] r_chk_idx;
    logic          r_found, r_free_found;
    logic [IW-1:0] r_match_idx, r_free_idx;
    logic          r_done;
    logic [1:0]    r_status, n_status;
    logic          r_slot_written, n_slot_written;
    logic [4:0]    r_slot, n_slot;

    logic          accept;
    logic [5:0]    hb;
    logic [31:0]   size_code;
    logic [CW-1:0] n_m1;
    logic          last_addr;
    logic [63:0]   cmp_base, store_base;
    logic          entry_hit, entry_free;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    t_win_entry    wr_data;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    // windows in use, saturated at the table depth
    always_comb begin
        if (32'(i_window_count) > MAX_WINDOWS) begin
            n_n = CW'(MAX_WINDOWS);
        end else begin
            n_n = CW'(i_window_count);
        end
    end

    // size code is hb - 2 modulo 2^32
    assign hb        = high_bit_pos(r_sum);
    assign size_code = (hb >= 6'd2) ? {26'd0, hb - 6'd2} : {31'h7FFF_FFFF, hb[0]};
    assign n_sw      = EN_BIT | (32'(r_target) << TARGET_LSB) | size_code;

    assign n_m1      = r_n - CW'(1);
    assign last_addr = (r_addr == n_m1[IW-1:0]);

    assign cmp_base   = i_wide_base_mode ? i_rd_entry.base : (i_rd_entry.base & SHORT_MASK);
    assign store_base = i_wide_base_mode ? r_base : (r_base & SHORT_MASK);
    assign entry_hit  = (i_rd_entry.status == r_sw) && (cmp_base == r_base);
    assign entry_free = !i_rd_entry.status[31];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SUM;
                end
            end
            S_SUM:  n_state = S_CODE;
            S_CODE: n_state = (r_n == '0) ? S_RESP : S_SCAN;
            S_SCAN: begin
                if (last_addr) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: n_state = S_RESP;
            S_RESP: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // decide the outcome once the scan has drained
    always_comb begin
        wr_en          = 1'b0;
        wr_idx         = r_free_idx;
        wr_data        = '0;
        n_status       = ST_OK;
        n_slot_written = 1'b0;
        n_slot         = 5'd0;
        if (r_opcode == OP_ENABLE) begin
            if (r_size != 32'd0 && !r_found) begin
                if (r_free_found) begin
                    wr_en          = 1'b1;
                    wr_data.base   = store_base;
                    wr_data.status = r_sw;
                    n_slot_written = 1'b1;
                    n_slot         = 5'(r_free_idx);
                end else begin
                    n_status = ST_NO_FREE;
                end
            end
        end else begin
            wr_idx = r_match_idx;
            if (r_found) begin
                wr_en          = 1'b1;
                n_slot_written = 1'b1;
                n_slot         = 5'(r_match_idx);
            end else begin
                n_status = ST_NOT_FOUND;
            end
        end
    end

    assign o_mem_req.rd_en   = (r_state == S_SCAN);
    assign o_mem_req.wr_en   = (r_state == S_RESP) && wr_en;
    assign o_mem_req.wr_data = wr_data;
    assign o_addr            = (r_state == S_RESP) ? wr_idx : r_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_done       <= 1'b0;
            r_chk        <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_RESP);
            r_chk   <= (r_state == S_SCAN);
            if (accept) begin
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
            end else if (r_chk) begin
                // keep the first hit and the lowest free window
                if (entry_hit) begin
                    r_found <= 1'b1;
                end
                if (entry_free) begin
                    r_free_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_opcode <= i_opcode;
            r_target <= i_target;
            r_base   <= i_base;
            r_size   <= i_size;
            r_n      <= n_n;
            r_addr   <= '0;
        end
        if (r_state == S_SUM) begin
            r_sum <= r_size + (r_size - 32'd1);
        end
        if (r_state == S_CODE) begin
            r_sw <= n_sw;
        end
        if (r_state == S_SCAN && !last_addr) begin
            r_addr <= r_addr + IW'(1);
        end
        r_chk_idx <= r_addr;
        if (r_chk && entry_hit && !r_found) begin
            r_match_idx <= r_chk_idx;
        end
        if (r_chk && entry_free && !r_free_found) begin
            r_free_idx <= r_chk_idx;
        end
        if (r_state == S_RESP) begin
            r_status       <= n_status;
            r_slot_written <= n_slot_written;
            r_slot         <= n_slot;
        end
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_slot_written = r_slot_written;
    assign o_slot         = r_slot;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while busy");

    a_write_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.wr_en |=> (o_done && o_slot_written))
        else $error("table write without a written-slot result");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_slot_written) |-> (o_slot == 5'd0))
        else $error("slot not zero when nothing written");

    a_err_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> !o_slot_written)
        else $error("error result with a written slot");

    a_chk_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk |-> ($past(r_state) == S_SCAN))
        else $error("entry check without a scan read");

endmodule
